// ===== design/bellman_ford_negative_cycle_unit_assert.svh =====
// Assertion macros for the bellman-ford unit.
`ifndef BELLMAN_FORD_NEGATIVE_CYCLE_UNIT_ASSERT_SVH
`define BELLMAN_FORD_NEGATIVE_CYCLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BFNC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFNC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define BFNC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BFNC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/bfnc_pkg.sv =====
package bfnc_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam int WEIGHT_BITS_DEF  = 32;
  localparam int VID_W  = 6;
  localparam int VCNT_W = 7;
  localparam int DIST_W = 64;
  localparam int WIN_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'd1;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;
  localparam logic [1:0] ST_FINITE      = 2'd0;
  localparam logic [1:0] ST_UNREACHABLE = 2'd1;
  localparam logic [1:0] ST_NEG_INF     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic init;        // clear flags, seed source
    logic edge_rd;     // issue edge read at edge index
    logic relax;       // relax edge whose data is on the read port
    logic last_pass;
    logic bfs_rd;      // issue edge read for BFS scan
    logic bfs_mark;    // mark head of the edge on the read port
    logic bfs_pop;     // advance queue head
    logic out_load;    // load result register for vertex index
    logic clear_edges;
  } bfnc_cmd_t;

  typedef struct packed {
    logic u_reached;
    logic queue_empty;
  } bfnc_sts_t;
endpackage

// ===== design/bfnc_if.sv =====
interface bfnc_in_if import bfnc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [VID_W-1:0] edge_from;
  logic [VID_W-1:0] edge_to;
  logic [WIN_W-1:0] edge_weight;
  modport source (output valid, action, edge_from, edge_to, edge_weight, input ready);
  modport sink (input valid, action, edge_from, edge_to, edge_weight, output ready);
endinterface

interface bfnc_out_if import bfnc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VID_W-1:0]  vertex;
  logic [1:0]        path_status;
  logic [DIST_W-1:0] distance;
  logic              edges_dropped;
  logic              last;
  modport source (output valid, vertex, path_status, distance, edges_dropped, last,
                  input ready);
  modport sink (input valid, vertex, path_status, distance, edges_dropped, last,
                output ready);
endinterface

// ===== design/bfnc_datapath.sv =====
module bfnc_datapath import bfnc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EC_W = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_we,
  input  logic [VID_W-1:0]  load_from,
  input  logic [VID_W-1:0]  load_to,
  input  logic [WIN_W-1:0]  load_weight,
  input  bfnc_cmd_t         cmd,
  input  logic [EA_W-1:0]   eidx,
  input  logic [VID_W-1:0]  uidx,
  input  logic [VCNT_W-1:0] n,
  input  logic [VID_W-1:0]  src,
  output bfnc_sts_t         sts,
  output logic [EC_W-1:0]   edge_count,
  output logic [VID_W-1:0]  res_vertex,
  output logic [1:0]        res_status,
  output logic [DIST_W-1:0] res_distance
);
  logic [VID_W-1:0]       tail_mem [MAX_EDGES];
  logic [VID_W-1:0]       head_mem [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] cost_mem [MAX_EDGES];
  logic [DIST_W-1:0]      dist_mem [MAX_VERTICES];
  logic [VID_W-1:0]       queue_mem [MAX_VERTICES];
  logic [VID_W-1:0]       tail_q, head_q;
  logic [WEIGHT_BITS-1:0] cost_q;
  logic [DIST_W-1:0]      du_q, dv_q, cand;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt, neg_r, neg_nxt;
  logic [VID_W:0]         qh_r, qh_nxt, qt_r, qt_nxt;
  logic [VID_W-1:0]       w_q;
  logic [EC_W-1:0]        ecnt_r, ecnt_nxt;
  logic                   hit, in_rng, qpush, bfs_hit;

  always_ff @(posedge clk) begin
    if (load_we) begin
      tail_mem[ecnt_r[EA_W-1:0]] <= load_from;
      head_mem[ecnt_r[EA_W-1:0]] <= load_to;
      cost_mem[ecnt_r[EA_W-1:0]] <= load_weight[WEIGHT_BITS-1:0];
    end
    if (cmd.edge_rd || cmd.bfs_rd) begin
      tail_q <= tail_mem[eidx];
      head_q <= head_mem[eidx];
      cost_q <= cost_mem[eidx];
    end
  end

  // distance memory: read u and the edge head, write relaxed head
  assign cand = du_q + {{(DIST_W-WEIGHT_BITS){cost_q[WEIGHT_BITS-1]}}, cost_q};
  assign in_rng = ({1'b0, head_q} < n);
  assign hit = cmd.relax && (tail_q == uidx) && in_rng &&
               (!reached_r[head_q] || ($signed(dv_q) > $signed(cand)));

  assign bfs_hit = cmd.bfs_mark && (tail_q == w_q) && in_rng && !neg_r[head_q];
  assign qpush = (hit && cmd.last_pass && !neg_r[head_q]) || bfs_hit;

  always_ff @(posedge clk) begin
    if (cmd.init) dist_mem[src] <= '0;
    else if (hit) dist_mem[head_q] <= cand;
    du_q <= dist_mem[uidx];
    dv_q <= dist_mem[head_q];
    if (cmd.bfs_pop) w_q <= queue_mem[qh_r[VID_W-1:0]];
    if (qpush) queue_mem[qt_r[VID_W-1:0]] <= head_q;
  end

  always_comb begin
    reached_nxt = reached_r;
    neg_nxt     = neg_r;
    qh_nxt      = qh_r;
    qt_nxt      = qt_r;
    ecnt_nxt    = ecnt_r;
    if (cmd.init) begin
      reached_nxt = '0;
      neg_nxt     = '0;
      qh_nxt      = '0;
      qt_nxt      = '0;
      if ({1'b0, src} < n) reached_nxt[src] = 1'b1;
    end
    if (hit) reached_nxt[head_q] = 1'b1;
    if (qpush) begin
      neg_nxt[head_q] = 1'b1;
      qt_nxt = qt_r + 1'b1;
    end
    if (cmd.bfs_pop) qh_nxt = qh_r + 1'b1;
    if (load_we) ecnt_nxt = ecnt_r + 1'b1;
    if (cmd.clear_edges) ecnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      neg_r     <= '0;
      qh_r      <= '0;
      qt_r      <= '0;
      ecnt_r    <= '0;
    end else begin
      reached_r <= reached_nxt;
      neg_r     <= neg_nxt;
      qh_r      <= qh_nxt;
      qt_r      <= qt_nxt;
      ecnt_r    <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_vertex   <= uidx;
      if (!reached_r[uidx]) begin
        res_status   <= ST_UNREACHABLE;
        res_distance <= '0;
      end else if (neg_r[uidx]) begin
        res_status   <= ST_NEG_INF;
        res_distance <= '0;
      end else begin
        res_status   <= ST_FINITE;
        res_distance <= dist_mem[uidx];
      end
    end
  end

  assign sts.u_reached   = reached_r[uidx];
  assign sts.queue_empty = (qh_r == qt_r);
  assign edge_count      = ecnt_r;
endmodule

// ===== design/bfnc_ctrl.sv =====
module bfnc_ctrl import bfnc_pkg::*; #(
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EC_W = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run_start,
  input  logic [VCNT_W-1:0] n,
  input  logic [EC_W-1:0]   edge_count,
  input  bfnc_sts_t         sts,
  input  logic              out_free,
  output bfnc_cmd_t         cmd,
  output logic [EA_W-1:0]   eidx,
  output logic [VID_W-1:0]  uidx,
  output logic              busy,
  output logic              out_set,
  output logic              out_last
);
  `include "bellman_ford_negative_cycle_unit_assert.svh"
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_VTX   = 7'b0000010,
    S_EDGE  = 7'b0000100,
    S_BPOP  = 7'b0001000,
    S_BEDGE = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;
  state_t state_r, state_nxt;
  logic [VID_W-1:0] u_r, u_nxt, p_r, p_nxt;
  logic [EC_W-1:0]  e_r, e_nxt;
  logic [1:0]       v_r, v_nxt;
  logic [VID_W-1:0] nm1;
  assign nm1 = VID_W'(n - 7'd1);

  always_comb begin
    state_nxt = state_r;
    u_nxt = u_r; p_nxt = p_r; e_nxt = e_r; v_nxt = '0;
    cmd = '0;
    out_set = 1'b0;
    case (state_r)
      S_IDLE: if (run_start) begin
        cmd.init = 1'b1; u_nxt = '0; p_nxt = '0; state_nxt = S_VTX;
      end
      S_VTX: begin
        e_nxt = '0;
        if (sts.u_reached && edge_count != '0) state_nxt = S_EDGE;
        else if (u_r == nm1) begin
          u_nxt = '0;
          if (p_r == nm1) state_nxt = S_BPOP;
          else p_nxt = p_r + 1'b1;
        end else u_nxt = u_r + 1'b1;
      end
      S_EDGE: begin
        // edge read, distance read, relax
        cmd.last_pass = (p_r == nm1);
        case (v_r)
          2'd0: begin
            cmd.edge_rd = 1'b1;
            v_nxt = 2'd1;
            e_nxt = e_r + 1'b1;
          end
          2'd1: v_nxt = 2'd2;
          default: begin
            cmd.relax = 1'b1;
            if (e_r == edge_count) begin
              state_nxt = S_VTX;
              if (u_r == nm1) begin
                u_nxt = '0;
                if (p_r == nm1) state_nxt = S_BPOP;
                else p_nxt = p_r + 1'b1;
              end else u_nxt = u_r + 1'b1;
            end
          end
        endcase
      end
      S_BPOP: begin
        e_nxt = '0;
        if (sts.queue_empty) begin u_nxt = '0; state_nxt = S_OUT; end
        else begin cmd.bfs_pop = 1'b1; state_nxt = S_BEDGE; end
      end
      S_BEDGE: begin
        if (v_r != 2'd0) begin
          cmd.bfs_mark = 1'b1;
          if (e_r == edge_count) state_nxt = S_BPOP;
        end else begin
          cmd.bfs_rd = 1'b1;
          v_nxt = 2'd1;
          e_nxt = e_r + 1'b1;
        end
      end
      S_OUT: if (out_free) begin
        cmd.out_load = 1'b1; out_set = 1'b1;
        if (u_r == nm1) begin cmd.clear_edges = 1'b1; state_nxt = S_WAIT; end
        else u_nxt = u_r + 1'b1;
      end
      S_WAIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign eidx = e_r[EA_W-1:0];
  assign uidx = u_r;
  assign busy = (state_r != S_IDLE);
  assign out_last = (u_r == nm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      u_r <= '0; p_r <= '0; e_r <= '0; v_r <= '0;
    end else begin
      state_r <= state_nxt;
      u_r <= u_nxt; p_r <= p_nxt; e_r <= e_nxt; v_r <= v_nxt;
    end
  end

  `BFNC_ASSERT_ALWAYS(a_onehot, clk, rst_n, $onehot(state_r), "state not one-hot")
  `BFNC_ASSERT_IMPL(a_start, clk, rst_n, (state_r == S_IDLE && run_start) |=> (state_r == S_VTX),
    "run did not start")
  `BFNC_ASSERT_ALWAYS(a_load, clk, rst_n, !(cmd.out_load && !out_free), "result overwritten")
endmodule

// ===== design/bellman_ford_negative_cycle_unit.sv =====
// Bellman-Ford shortest paths with negative-cycle detection. Edge loads (action 0) are
// taken one per cycle into a MAX_EDGES-entry edge memory. A run (action 1) makes
// vertex_count passes (clamped to 1..MAX_VERTICES); in each pass every vertex is
// visited and a reached vertex takes each stored edge through edge read, distance
// read and relax, as the single edge memory read port is scanned per vertex. The
// breadth-first marking then pops each queued vertex and scans every stored edge for
// it (edge read, mark), and the results come out one per cycle while the receiver
// takes them. No input is taken while a run is in progress.
module bellman_ford_negative_cycle_unit import bfnc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bfnc_in_if.sink               in_ch,
  bfnc_out_if.source            out_ch
);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  logic [VCNT_W-1:0] vc_r, n;
  logic [VID_W-1:0]  src_r, uidx;
  logic [EA_W-1:0]   eidx;
  logic [EC_W-1:0]   ecnt;
  bfnc_cmd_t cmd;
  bfnc_sts_t sts;
  logic busy, out_set, out_last, ov_r, last_r, out_free, acc, load_we, run_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 7'd1; src_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vc_r <= cfg_data[VCNT_W-1:0];
        CFG_SOURCE_VERTEX: src_r <= cfg_data[VID_W-1:0];
        default: ;
      endcase
    end
  end

  assign n = (vc_r == '0) ? 7'd1 :
             (vc_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc_r;

  assign in_ch.ready = rst_n && !busy;
  assign acc = in_ch.valid && in_ch.ready;
  assign load_we = acc && in_ch.action == ACT_LOAD && ecnt != EC_W'(MAX_EDGES);
  assign run_start = acc && in_ch.action == ACT_RUN;
  assign out_free = !ov_r || out_ch.ready;

  bfnc_ctrl #(.MAX_EDGES(MAX_EDGES)) u_ctrl (
    .clk, .rst_n, .run_start, .n, .edge_count(ecnt), .sts, .out_free, .cmd, .eidx,
    .uidx, .busy, .out_set, .out_last
  );

  logic drop_r;
  bfnc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
                  .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk, .rst_n, .load_we, .load_from(in_ch.edge_from), .load_to(in_ch.edge_to),
    .load_weight(in_ch.edge_weight), .cmd, .eidx, .uidx, .n, .src(src_r), .sts,
    .edge_count(ecnt), .res_vertex(out_ch.vertex), .res_status(out_ch.path_status),
    .res_distance(out_ch.distance)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; last_r <= 1'b0; drop_r <= 1'b0;
    end else begin
      if (out_set) begin ov_r <= 1'b1; last_r <= out_last; end
      else if (out_ch.ready) ov_r <= 1'b0;
      if (acc && in_ch.action == ACT_LOAD && ecnt == EC_W'(MAX_EDGES)) drop_r <= 1'b1;
      else if (cmd.clear_edges) drop_r <= 1'b0;
    end
  end

  logic dr_out_r;
  always_ff @(posedge clk) if (out_set) dr_out_r <= drop_r;

  assign out_ch.valid = ov_r;
  assign out_ch.last = last_r;
  assign out_ch.edges_dropped = dr_out_r;
endmodule
